>>> src/mahp_pkg.sv
// shared types, constants and lookup functions for the audio header parser
package mahp_pkg;

  localparam int unsigned WindowMaxDefault = 4096;

  localparam logic [1:0] StatusOk       = 2'd0;
  localparam logic [1:0] StatusBadVer   = 2'd1;
  localparam logic [1:0] StatusNoSync   = 2'd2;

  localparam logic CfgFileSize = 1'b0;
  localparam logic CfgSearchLimit = 1'b1;

  typedef enum logic [1:0] {
    PhSearch = 2'd0,
    PhByte3  = 2'd1,
    PhByte4  = 2'd2,
    PhDone   = 2'd3
  } phase_e;

  typedef enum logic [2:0] {
    StIdle,
    StDivFb,
    StDivFrames,
    StMul,
    StDivDur,
    StOut
  } calc_e;

  // bitrate table, kbps
  function automatic logic [8:0] bitrate_lookup(input logic v1, input logic [1:0] lay,
                                                input logic [3:0] idx);
    logic [8:0] r;
    r = 9'd0;
    if (v1) begin
      unique case (lay)
        2'd1: case (idx)
          4'd1: r = 9'd32; 4'd2: r = 9'd64; 4'd3: r = 9'd96; 4'd4: r = 9'd128;
          4'd5: r = 9'd160; 4'd6: r = 9'd192; 4'd7: r = 9'd224; 4'd8: r = 9'd256;
          4'd9: r = 9'd288; 4'd10: r = 9'd320; 4'd11: r = 9'd352; 4'd12: r = 9'd384;
          4'd13: r = 9'd416; 4'd14: r = 9'd448; default: r = 9'd0;
        endcase
        2'd2: case (idx)
          4'd1: r = 9'd32; 4'd2: r = 9'd48; 4'd3: r = 9'd56; 4'd4: r = 9'd64;
          4'd5: r = 9'd80; 4'd6: r = 9'd96; 4'd7: r = 9'd112; 4'd8: r = 9'd128;
          4'd9: r = 9'd160; 4'd10: r = 9'd192; 4'd11: r = 9'd224; 4'd12: r = 9'd256;
          4'd13: r = 9'd320; 4'd14: r = 9'd384; default: r = 9'd0;
        endcase
        2'd3: case (idx)
          4'd1: r = 9'd32; 4'd2: r = 9'd40; 4'd3: r = 9'd48; 4'd4: r = 9'd56;
          4'd5: r = 9'd64; 4'd6: r = 9'd80; 4'd7: r = 9'd96; 4'd8: r = 9'd112;
          4'd9: r = 9'd128; 4'd10: r = 9'd160; 4'd11: r = 9'd192; 4'd12: r = 9'd224;
          4'd13: r = 9'd256; 4'd14: r = 9'd320; default: r = 9'd0;
        endcase
        default: r = 9'd0;
      endcase
    end else begin
      unique case (lay)
        2'd1: case (idx)
          4'd1: r = 9'd32; 4'd2: r = 9'd48; 4'd3: r = 9'd56; 4'd4: r = 9'd64;
          4'd5: r = 9'd80; 4'd6: r = 9'd96; 4'd7: r = 9'd112; 4'd8: r = 9'd128;
          4'd9: r = 9'd144; 4'd10: r = 9'd160; 4'd11: r = 9'd176; 4'd12: r = 9'd192;
          4'd13: r = 9'd224; 4'd14: r = 9'd256; default: r = 9'd0;
        endcase
        2'd2, 2'd3: case (idx)
          4'd1: r = 9'd8; 4'd2: r = 9'd16; 4'd3: r = 9'd24; 4'd4: r = 9'd32;
          4'd5: r = 9'd40; 4'd6: r = 9'd48; 4'd7: r = 9'd56; 4'd8: r = 9'd64;
          4'd9: r = 9'd80; 4'd10: r = 9'd96; 4'd11: r = 9'd112; 4'd12: r = 9'd128;
          4'd13: r = 9'd144; 4'd14: r = 9'd160; default: r = 9'd0;
        endcase
        default: r = 9'd0;
      endcase
    end
    return r;
  endfunction

  function automatic logic [15:0] rate_lookup(input logic [1:0] ver, input logic [1:0] fidx);
    logic [15:0] r;
    r = 16'd0;
    unique case (ver)
      2'd0: case (fidx)
        2'd0: r = 16'd44100; 2'd1: r = 16'd48000; 2'd2: r = 16'd32000; default: r = 16'd0;
      endcase
      2'd1: case (fidx)
        2'd0: r = 16'd22050; 2'd1: r = 16'd24000; 2'd2: r = 16'd16000; default: r = 16'd0;
      endcase
      2'd2: case (fidx)
        2'd0: r = 16'd11025; 2'd1: r = 16'd12000; 2'd2: r = 16'd8000; default: r = 16'd0;
      endcase
      default: r = 16'd0;
    endcase
    return r;
  endfunction

endpackage

>>> src/mahp_divider.sv
// restoring divider, one quotient bit per cycle
module mahp_divider (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [47:0] dividend_i,
  input  logic [31:0] divisor_i,
  output logic        done_o,
  output logic [47:0] quotient_o
);

  logic [47:0] quo_q, quo_d;
  logic [32:0] rem_q, rem_d;
  logic [31:0] dvs_q, dvs_d;
  logic [5:0]  cnt_q, cnt_d;
  logic        busy_q, busy_d;
  logic        done_q, done_d;
  logic [32:0] trial;

  always_comb begin
    quo_d  = quo_q;
    rem_d  = rem_q;
    dvs_d  = dvs_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    trial  = {rem_q[31:0], quo_q[47]};
    if (start_i) begin
      quo_d  = dividend_i;
      rem_d  = 33'd0;
      dvs_d  = divisor_i;
      cnt_d  = 6'd47;
      busy_d = 1'b1;
    end else if (busy_q) begin
      // shift one dividend bit into the remainder, subtract if it fits
      if (trial >= {1'b0, dvs_q}) begin
        rem_d = trial - {1'b0, dvs_q};
        quo_d = {quo_q[46:0], 1'b1};
      end else begin
        rem_d = trial;
        quo_d = {quo_q[46:0], 1'b0};
      end
      if (cnt_q == 6'd0) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end else begin
        cnt_d = cnt_q - 6'd1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= 6'd0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    dvs_q <= dvs_d;
  end

  assign done_o     = done_q;
  assign quotient_o = quo_q;

endmodule

>>> src/mpeg_audio_header_parser.sv
// mpeg audio header parser top level: byte search, header decode, frame math
// a result follows the fourth header byte after three divisions and one multiply,
//   or directly when the layer, bitrate or sample rate field is unusable
// throughput: one byte per cycle in search with no result pending; none is taken during the math
// a failure result is ready the cycle after the byte that causes it
// reset clears phase and counters, config registers take their defaults; header bytes stay unset
module mpeg_audio_header_parser #(
  parameter int unsigned WINDOW_MAX = mahp_pkg::WindowMaxDefault
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic        cfg_index_i,
  input  logic [31:0] cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  data_byte_i,
  input  logic        first_byte_i,
  input  logic        last_byte_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [1:0]  status_o,
  output logic [1:0]  mpeg_version_o,
  output logic [1:0]  layer_number_o,
  output logic [8:0]  bitrate_kbps_o,
  output logic [15:0] sample_rate_hz_o,
  output logic [10:0] frame_bytes_o,
  output logic [10:0] samples_per_frame_o,
  output logic [1:0]  channel_count_o,
  output logic [31:0] total_frames_o,
  output logic [31:0] duration_seconds_o,
  output logic [15:0] header_tail_o
);

  localparam int unsigned LimW = $clog2(WINDOW_MAX + 1) > 13 ? $clog2(WINDOW_MAX + 1) : 13;

  logic [31:0] fsize_q;
  logic [12:0] slimit_q;
  logic        prev_ff_q, prev_ff_d;
  mahp_pkg::phase_e phase_q, phase_d;
  logic [12:0] seen_q, seen_d;
  logic [7:0]  hb2_q, hb3_q;
  logic        hb2_we, hb3_we;
  mahp_pkg::calc_e calc_q, calc_d;

  // result register
  logic        ov_q;
  logic [1:0]  st_q, ver_q, lay_q, ch_q;
  logic [8:0]  br_q;
  logic [15:0] sr_q, tail_q;
  logic [10:0] fb_q, spf_q;
  logic [31:0] frames_q, dur_q;
  logic        pad_q;

  logic        in_acc, out_acc;
  logic        fail_set;
  logic [1:0]  fail_st;
  logic        dec_start;

  assign in_acc  = in_valid_i && !in_stall_o;
  assign out_acc = ov_q && !out_stall_i;
  assign in_stall_o = ov_q || (calc_q != mahp_pkg::StIdle);

  // window limit, clamped to the parameter
  logic [LimW-1:0] lim;
  logic [LimW-1:0] idx_w;
  assign lim = (LimW'(slimit_q) > LimW'(WINDOW_MAX)) ? LimW'(WINDOW_MAX) : LimW'(slimit_q);

  logic        sync_hit;
  logic [1:0]  cur_phase;
  logic        eff_prev;
  logic [12:0] eff_seen;

  always_comb begin
    eff_prev  = first_byte_i ? 1'b0 : prev_ff_q;
    eff_seen  = first_byte_i ? 13'd0 : seen_q;
    cur_phase = first_byte_i ? mahp_pkg::PhSearch : phase_q;
    idx_w     = LimW'(eff_seen);
    sync_hit  = eff_prev && (data_byte_i[7:4] == 4'hF);
  end

  always_comb begin
    phase_d   = phase_q;
    prev_ff_d = prev_ff_q;
    seen_d    = seen_q;
    hb2_we    = 1'b0;
    hb3_we    = 1'b0;
    fail_set  = 1'b0;
    fail_st   = mahp_pkg::StatusNoSync;
    dec_start = 1'b0;
    if (in_acc) begin
      phase_d   = mahp_pkg::phase_e'(cur_phase);
      prev_ff_d = eff_prev;
      seen_d    = eff_seen;
      unique case (mahp_pkg::phase_e'(cur_phase))
        mahp_pkg::PhSearch: begin
          if (eff_seen != 13'h1FFF) seen_d = eff_seen + 13'd1;
          if (sync_hit) begin
            prev_ff_d = 1'b0;
            if (data_byte_i[4:3] == 2'b01) begin
              fail_set = 1'b1;
              fail_st  = mahp_pkg::StatusBadVer;
            end else begin
              hb2_we = 1'b1;
              if (last_byte_i) fail_set = 1'b1;
              else phase_d = mahp_pkg::PhByte3;
            end
          end else begin
            prev_ff_d = (data_byte_i == 8'hFF) && (idx_w < lim);
            if ((!prev_ff_d && (({1'b0, idx_w} + {{LimW{1'b0}}, 1'b1}) >= {1'b0, lim}))
                || last_byte_i) fail_set = 1'b1;
          end
        end
        mahp_pkg::PhByte3: begin
          hb3_we = 1'b1;
          if (last_byte_i) fail_set = 1'b1;
          else phase_d = mahp_pkg::PhByte4;
        end
        mahp_pkg::PhByte4: begin
          dec_start = 1'b1;
          phase_d   = mahp_pkg::PhDone;
        end
        mahp_pkg::PhDone: ;
        default: ;
      endcase
      if (fail_set) phase_d = mahp_pkg::PhDone;
    end
  end

  // header field decode from stored bytes and the fourth byte
  logic [1:0]  dver, dlay;
  logic [8:0]  dbr;
  logic [15:0] dsr;
  logic [10:0] dspf;
  always_comb begin
    unique case (hb2_q[4:3])
      2'b11:   dver = 2'd0;
      2'b10:   dver = 2'd1;
      default: dver = 2'd2;
    endcase
    dlay = (hb2_q[2:1] == 2'd0) ? 2'd0 : 2'(3'd4 - {1'b0, hb2_q[2:1]});
    dbr  = mahp_pkg::bitrate_lookup(dver == 2'd0, dlay, hb3_q[7:4]);
    dsr  = mahp_pkg::rate_lookup(dver, hb3_q[3:2]);
    if (dlay == 2'd3) dspf = (dver == 2'd0) ? 11'd1152 : 11'd576;
    else if (dlay == 2'd2) dspf = 11'd1152;
    else dspf = 11'd384;
  end

  // divider sequencing
  logic        div_start, div_done;
  logic [47:0] div_num, div_q;
  logic [31:0] div_den;
  logic [17:0] factor;
  logic [47:0] prod_q;
  logic [12:0] fb_raw;
  logic        dur_wait_q;

  always_comb begin
    if (lay_q == 2'd1) factor = 18'd12000;
    else if (lay_q == 2'd3 && ver_q != 2'd0) factor = 18'd72000;
    else factor = 18'd144000;
  end

  always_comb begin
    calc_d    = calc_q;
    div_start = 1'b0;
    div_num   = 48'd0;
    div_den   = 32'd1;
    unique case (calc_q)
      mahp_pkg::StIdle: if (dec_start) calc_d = mahp_pkg::StDivFb;
      mahp_pkg::StDivFb: begin
        if (lay_q == 2'd0 || br_q == 9'd0 || sr_q == 16'd0) begin
          calc_d = mahp_pkg::StOut;
        end else begin
          div_start = 1'b1;
          div_num   = 48'(factor * br_q);
          div_den   = 32'(sr_q);
          calc_d    = mahp_pkg::StDivFrames;
        end
      end
      mahp_pkg::StDivFrames: begin
        if (div_done) begin
          div_start = 1'b1;
          div_num   = 48'(fsize_q);
          div_den   = 32'(fb_raw > 13'd2047 ? 11'd2047 : fb_raw[10:0]);
          calc_d    = mahp_pkg::StMul;
        end
      end
      mahp_pkg::StMul: if (div_done) calc_d = mahp_pkg::StDivDur;
      mahp_pkg::StDivDur: begin
        div_start = 1'b1;
        div_num   = prod_q;
        div_den   = 32'(sr_q);
        calc_d    = mahp_pkg::StOut;
      end
      // wait for the duration division unless the math was skipped
      mahp_pkg::StOut: if (!dur_wait_q || div_done) calc_d = mahp_pkg::StIdle;
      default: calc_d = mahp_pkg::StIdle;
    endcase
  end

  // frame length before clamping: layer one is in four-byte slots
  always_comb begin
    if (lay_q == 2'd1) fb_raw = {div_q[10:0] + {10'd0, pad_q}, 2'b00};
    else fb_raw = div_q[12:0] + {12'd0, pad_q};
  end

  mahp_divider u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_num),
    .divisor_i  (div_den),
    .done_o     (div_done),
    .quotient_o (div_q)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fsize_q   <= 32'd0;
      slimit_q  <= 13'd4092;
      prev_ff_q <= 1'b0;
      phase_q   <= mahp_pkg::PhSearch;
      seen_q    <= 13'd0;
      calc_q    <= mahp_pkg::StIdle;
      ov_q      <= 1'b0;
      dur_wait_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_index_i)
          mahp_pkg::CfgFileSize:    fsize_q  <= cfg_data_i;
          mahp_pkg::CfgSearchLimit: slimit_q <= cfg_data_i[12:0];
          default: ;
        endcase
      end
      prev_ff_q <= prev_ff_d;
      phase_q   <= phase_d;
      seen_q    <= seen_d;
      calc_q    <= calc_d;
      dur_wait_q <= (calc_d == mahp_pkg::StOut) &&
                    ((calc_q == mahp_pkg::StDivDur) || dur_wait_q);
      if (out_acc) ov_q <= 1'b0;
      else if (fail_set) ov_q <= 1'b1;
      else if (calc_q == mahp_pkg::StOut && calc_d == mahp_pkg::StIdle) ov_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (hb2_we) hb2_q <= data_byte_i;
    if (hb3_we) hb3_q <= data_byte_i;
    if (fail_set) begin
      st_q <= fail_st; ver_q <= 2'd0; lay_q <= 2'd0; br_q <= 9'd0; sr_q <= 16'd0;
      fb_q <= 11'd0; spf_q <= 11'd0; ch_q <= 2'd0; frames_q <= 32'd0; dur_q <= 32'd0;
      tail_q <= 16'd0;
    end else if (dec_start) begin
      st_q  <= mahp_pkg::StatusOk;
      ver_q <= dver; lay_q <= dlay; br_q <= (dlay == 2'd0) ? 9'd0 : dbr; sr_q <= dsr;
      spf_q <= dspf; pad_q <= hb3_q[1];
      ch_q  <= (data_byte_i[7:6] == 2'b11) ? 2'd1 : 2'd2;
      tail_q <= {hb3_q, data_byte_i};
      fb_q <= 11'd0; frames_q <= 32'd0; dur_q <= 32'd0;
    end else begin
      unique case (calc_q)
        mahp_pkg::StDivFrames: if (div_done) begin
          fb_q <= (fb_raw > 13'd2047) ? 11'd2047 : fb_raw[10:0];
        end
        mahp_pkg::StMul: if (div_done) begin
          frames_q <= div_q[31:0];
          prod_q   <= 48'(div_q[31:0] * spf_q);
        end
        mahp_pkg::StOut: if (div_done) dur_q <= div_q[31:0];
        default: ;
      endcase
    end
  end

  assign out_valid_o         = ov_q;
  assign status_o            = st_q;
  assign mpeg_version_o      = ver_q;
  assign layer_number_o      = lay_q;
  assign bitrate_kbps_o      = br_q;
  assign sample_rate_hz_o    = sr_q;
  assign frame_bytes_o       = fb_q;
  assign samples_per_frame_o = spf_q;
  assign channel_count_o     = ch_q;
  assign total_frames_o      = frames_q;
  assign duration_seconds_o  = dur_q;
  assign header_tail_o       = tail_q;

  // no input taken while math runs
  a_no_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (calc_q != mahp_pkg::StIdle) |-> !in_acc) else $error("input taken during math");
  // a pending result holds until taken
  a_result_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ov_q && out_stall_i) |=> (ov_q && $stable(st_q) && $stable(frames_q)))
    else $error("result changed while stalled");
  // failure results carry zero fields
  a_fail_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ov_q && st_q != mahp_pkg::StatusOk) |-> (frames_q == 32'd0 && fb_q == 11'd0))
    else $error("failure result with nonzero fields");

endmodule
